@@ hw/rtl/hsfd_pkg.sv @@
// shared types, constants and the crc-8 byte step for the sensor frame decoder
// no dependencies

package hsfd_pkg;

   typedef logic [7:0]         byte_type;
   typedef logic [7:0]         csr_index_type;
   typedef logic [15:0]        raw_word_type;
   typedef logic signed [14:0] temp_centi_type;
   typedef logic [13:0]        hum_centi_type;

   // configuration register indexes
   localparam csr_index_type CSR_IDX_POLY = 8'd0;
   localparam csr_index_type CSR_IDX_INIT = 8'd1;

   localparam byte_type CRC_POLY_RESET = 8'h31;
   localparam byte_type CRC_INIT_RESET = 8'hFF;

   // scaling constants, centi units
   localparam logic [14:0] TEMP_SCALE  = 15'd17500;
   localparam logic [13:0] HUM_SCALE   = 14'd12500;
   localparam logic [15:0] TEMP_OFFSET = 16'd4500;
   localparam logic [13:0] HUM_OFFSET  = 14'd600;
   localparam logic [13:0] HUM_MAX     = 14'd10000;

   // byte position within a response frame
   typedef enum logic [2:0] {
      POS_T_HI   = 3'd0,
      POS_T_LO   = 3'd1,
      POS_T_CRC  = 3'd2,
      POS_RH_HI  = 3'd3,
      POS_RH_LO  = 3'd4,
      POS_RH_CRC = 3'd5
   } pos_type;

   // completed frame handed from front to back
   typedef struct packed {
      raw_word_type raw_temperature;
      raw_word_type raw_humidity;
      logic         crc_fail;
   } frame_type;

   // one data byte through the crc-8, msb first
   function automatic byte_type crc8_byte(input byte_type acc, input byte_type data,
                                          input byte_type poly);
      byte_type c;
      c = acc ^ data;
      for (int b = 0; b < 8; b++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage

@@ hw/rtl/hsfd_if.sv @@
// channel interfaces of the sensor frame decoder: byte input, result output, csr writes
// depends on hsfd_pkg

interface hsfd_req_if;
   logic               valid;
   logic               ready;
   hsfd_pkg::byte_type rx_byte;
   logic               first_byte;

   modport source (output valid, output rx_byte, output first_byte, input ready);
   modport sink   (input valid, input rx_byte, input first_byte, output ready);
endinterface

interface hsfd_rsp_if;
   logic                     valid;
   logic                     ready;
   hsfd_pkg::temp_centi_type temperature_centi;
   hsfd_pkg::hum_centi_type  humidity_centi;
   hsfd_pkg::raw_word_type   raw_temperature;
   hsfd_pkg::raw_word_type   raw_humidity;
   logic                     crc_fail;

   modport source (output valid, output temperature_centi, output humidity_centi,
                   output raw_temperature, output raw_humidity, output crc_fail,
                   input ready);
   modport sink   (input valid, input temperature_centi, input humidity_centi,
                   input raw_temperature, input raw_humidity, input crc_fail,
                   output ready);
endinterface

interface hsfd_csr_if;
   logic                    valid;
   logic                    ready;
   hsfd_pkg::csr_index_type index;
   hsfd_pkg::byte_type      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/hsfd_front.sv @@
// front end: byte position tracking, crc-8 checking, word assembly, csr registers
// depends on hsfd_pkg and hsfd_if

module hsfd_front (
   input  logic                clock,
   input  logic                reset,
   hsfd_req_if.sink            req_ch,
   hsfd_csr_if.sink            csr_ch,
   input  logic                queue_full,
   output logic                push,
   output hsfd_pkg::frame_type push_frame
);
   import hsfd_pkg::*;

   byte_type     poly_ff, init_ff;
   pos_type      pos_ff, pos_in, pos_eff;
   byte_type     acc_ff, acc_in;
   raw_word_type t_word_ff, t_word_in;
   raw_word_type h_word_ff, h_word_in;
   logic         bad_ff, bad_in;
   logic         accept;
   byte_type     crc_seed, crc_out;

   assign req_ch.ready = !queue_full;
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && req_ch.ready;

   // a start mark or an unreachable code restarts at the temperature high byte
   always_comb begin
      if (req_ch.first_byte) begin
         pos_eff = POS_T_HI;
      end else begin
         unique case (pos_ff)
            POS_T_HI, POS_T_LO, POS_T_CRC, POS_RH_HI, POS_RH_LO, POS_RH_CRC:
               pos_eff = pos_ff;
            default:
               pos_eff = POS_T_HI;
         endcase
      end
   end

   // next position
   always_comb begin
      unique case (pos_eff)
         POS_T_HI:   pos_in = POS_T_LO;
         POS_T_LO:   pos_in = POS_T_CRC;
         POS_T_CRC:  pos_in = POS_RH_HI;
         POS_RH_HI:  pos_in = POS_RH_LO;
         POS_RH_LO:  pos_in = POS_RH_CRC;
         default:    pos_in = POS_T_HI;
      endcase
   end

   assign crc_seed = (pos_eff == POS_T_HI || pos_eff == POS_RH_HI) ? init_ff : acc_ff;
   assign crc_out  = crc8_byte(crc_seed, req_ch.rx_byte, poly_ff);

   // datapath per position
   always_comb begin
      acc_in     = acc_ff;
      t_word_in  = t_word_ff;
      h_word_in  = h_word_ff;
      bad_in     = bad_ff;
      push       = 1'b0;
      push_frame.raw_temperature = t_word_ff;
      push_frame.raw_humidity    = h_word_ff;
      push_frame.crc_fail        = bad_ff || (acc_ff != req_ch.rx_byte);
      unique case (pos_eff)
         POS_T_HI: begin
            t_word_in = {req_ch.rx_byte, 8'h00};
            acc_in    = crc_out;
         end
         POS_T_LO: begin
            t_word_in = {t_word_ff[15:8], req_ch.rx_byte};
            acc_in    = crc_out;
         end
         POS_T_CRC: begin
            bad_in = (acc_ff != req_ch.rx_byte);
            acc_in = init_ff;
         end
         POS_RH_HI: begin
            h_word_in = {req_ch.rx_byte, 8'h00};
            acc_in    = crc_out;
         end
         POS_RH_LO: begin
            h_word_in = {h_word_ff[15:8], req_ch.rx_byte};
            acc_in    = crc_out;
         end
         default: begin
            acc_in = init_ff;
            push   = accept;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff   <= CRC_POLY_RESET;
         init_ff   <= CRC_INIT_RESET;
         pos_ff    <= POS_T_HI;
         acc_ff    <= CRC_INIT_RESET;
         t_word_ff <= '0;
         h_word_ff <= '0;
         bad_ff    <= 1'b0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == CSR_IDX_POLY) begin
               poly_ff <= csr_ch.data;
            end
            if (csr_ch.index == CSR_IDX_INIT) begin
               init_ff <= csr_ch.data;
            end
         end
         if (accept) begin
            pos_ff    <= pos_in;
            acc_ff    <= acc_in;
            t_word_ff <= t_word_in;
            h_word_ff <= h_word_in;
            bad_ff    <= bad_in;
         end
      end
   end

endmodule

@@ hw/rtl/hsfd_queue.sv @@
// small frame queue between front and back ends
// depends on hsfd_pkg

module hsfd_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hsfd_pkg::frame_type push_frame,
   output logic                full,
   input  logic                pop_req,
   output logic                pop_valid,
   output hsfd_pkg::frame_type pop_frame
);
   import hsfd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   frame_type        mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop       = pop_req && pop_valid;
   assign pop_frame = mem[rd_ptr_ff];
   assign count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

@@ hw/rtl/hsfd_back.sv @@
// back end: scaling pipeline (multiply, divide by 65535, offset and clamp) and result register
// depends on hsfd_pkg and hsfd_if

module hsfd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                frame_valid,
   input  hsfd_pkg::frame_type frame,
   output logic                frame_pop,
   hsfd_rsp_if.source          rsp_ch
);
   import hsfd_pkg::*;

   logic           advance;
   // stage 1: products
   logic           v1_ff;
   logic [30:0]    prod_t_ff, prod_t_in;
   logic [29:0]    prod_h_ff, prod_h_in;
   frame_type      f1_ff;
   // stage 2: quotients
   logic           v2_ff;
   logic [14:0]    qt_ff, qt_in;
   logic [13:0]    qh_ff, qh_in;
   frame_type      f2_ff;
   logic [31:0]    sum_t;
   logic [29:0]    sum_h;
   // stage 3: result register
   logic           rsp_valid_ff;
   temp_centi_type temp_ff, temp_in;
   hum_centi_type  hum_ff, hum_in;
   frame_type      f3_ff;
   logic [15:0]    temp_wide;
   logic [13:0]    hum_diff;

   // whole pipeline moves when the result register is free or being taken
   assign advance   = !rsp_valid_ff || rsp_ch.ready;
   assign frame_pop = advance;

   assign prod_t_in = 31'(31'(TEMP_SCALE) * 31'(frame.raw_temperature));
   assign prod_h_in = 30'(30'(HUM_SCALE) * 30'(frame.raw_humidity));

   // floor(x/65535) = (x + (x >> 16) + 1) >> 16 for the product range here
   assign sum_t = 32'(prod_t_ff) + 32'(prod_t_ff >> 16) + 32'd1;
   assign sum_h = prod_h_ff + (prod_h_ff >> 16) + 30'd1;
   assign qt_in = sum_t[30:16];
   assign qh_in = sum_h[29:16];

   assign temp_wide = 16'(qt_ff) - TEMP_OFFSET;
   assign temp_in   = temp_wide[14:0];
   assign hum_diff  = qh_ff - HUM_OFFSET;

   always_comb begin
      priority if (qh_ff < HUM_OFFSET) begin
         hum_in = '0;
      end else if (hum_diff > HUM_MAX) begin
         hum_in = HUM_MAX;
      end else begin
         hum_in = hum_diff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= frame_valid;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_t_ff <= prod_t_in;
         prod_h_ff <= prod_h_in;
         f1_ff     <= frame;
         qt_ff     <= qt_in;
         qh_ff     <= qh_in;
         f2_ff     <= f1_ff;
         temp_ff   <= temp_in;
         hum_ff    <= hum_in;
         f3_ff     <= f2_ff;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.temperature_centi = temp_ff;
   assign rsp_ch.humidity_centi    = hum_ff;
   assign rsp_ch.raw_temperature   = f3_ff.raw_temperature;
   assign rsp_ch.raw_humidity      = f3_ff.raw_humidity;
   assign rsp_ch.crc_fail          = f3_ff.crc_fail;

endmodule

@@ hw/rtl/humidity_sensor_frame_decoder.sv @@
// top level of the sensor frame decoder: front end, frame queue, scaling back end
// depends on hsfd_pkg, hsfd_if, hsfd_front, hsfd_queue, hsfd_back
//
// usage:
//   req_ch takes one response byte per transfer in wire order: temperature high,
//   temperature low, temperature crc, humidity high, humidity low, humidity crc.
//   first_byte marks the start of a frame and drops any partial frame.
//   rsp_ch gives one result per six bytes: raw words, crc_fail, and the scaled
//   temperature and humidity in hundredths.
//   csr_ch writes the crc polynomial (index 0) and the crc start value (index 1);
//   it is always ready and should be written only while the block is idle.
// throughput: one byte per cycle unless the queue is full (req_ch not ready).
// path: after the transfer of its sixth byte, a frame goes through the queue
//   write, product stage, quotient stage and result register to rsp_ch.
// reset: position returns to the first byte, crc registers go to 0x31 and 0xFF.
// stall: when rsp_ch is stalled the scaling pipeline holds; finished frames
//   collect in a QUEUE_DEPTH entry queue, and req_ch drops ready only when
//   that queue is full.

module humidity_sensor_frame_decoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   hsfd_req_if.sink   req_ch,
   hsfd_rsp_if.source rsp_ch,
   hsfd_csr_if.sink   csr_ch
);
   import hsfd_pkg::*;

   logic      queue_full;
   logic      push;
   frame_type push_frame;
   logic      pop_req;
   logic      pop_valid;
   frame_type pop_frame;

   hsfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_frame (push_frame)
   );

   hsfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .full       (queue_full),
      .pop_req    (pop_req),
      .pop_valid  (pop_valid),
      .pop_frame  (pop_frame)
   );

   hsfd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (pop_valid),
      .frame       (pop_frame),
      .frame_pop   (pop_req),
      .rsp_ch      (rsp_ch)
   );

endmodule
